>>> rtl/nrg_pkg.sv
// Shared types, character codes and arithmetic constants for the NMEA RMC/GGA parser.
// No dependencies; every other file of the block but nrg_fifo imports this package.
`timescale 1ns / 1ps
package nrg_pkg;

  localparam int MAX_LEN     = 128;
  localparam int FRAC_DIGITS = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;

  localparam logic [39:0] ADDR_GPRMC = "GPRMC";
  localparam logic [39:0] ADDR_GNRMC = "GNRMC";
  localparam logic [39:0] ADDR_GPGGA = "GPGGA";
  localparam logic [39:0] ADDR_GNGGA = "GNGGA";

  localparam logic [2:0] ST_RMC_OK = 3'd0;
  localparam logic [2:0] ST_GGA_OK = 3'd1;
  localparam logic [2:0] ST_OTHER  = 3'd2;
  localparam logic [2:0] ST_VOID   = 3'd3;
  localparam logic [2:0] ST_BAD    = 3'd4;

  localparam logic [29:0] INT_CAP   = 30'd1000000000;
  localparam logic [31:0] LAT_LIMIT = 32'd900000000;
  localparam logic [31:0] LON_LIMIT = 32'd1800000000;
  localparam logic [21:0] SPD_LIMIT = 22'd2000000;
  localparam logic [24:0] ALT_LIMIT = 25'd9999999;
  localparam logic [24:0] ALT_NEG_LIMIT = 25'd99999;

  // Reciprocals: x/15 = (x*M15)>>35, z/78125 = (z*M78125)>>44, f/100000 = (f*M1E5)>>41.
  localparam logic [31:0] M15     = 32'd2290649225;
  localparam logic [31:0] M78125  = 32'd225179982;
  localparam logic [31:0] M1E5    = 32'd21990233;

  // Weight of each fraction digit, normalized to seven decimal places.
  localparam logic [23:0] FRAC_W [7] = '{24'd1000000, 24'd100000, 24'd10000, 24'd1000,
                                         24'd100, 24'd10, 24'd1};

  typedef enum logic [2:0] {
    OP_NONE, OP_LAT, OP_LON, OP_SPD, OP_ALT, OP_SAT, OP_EOL
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [29:0] int_val;
    logic [7:0]  deg;
    logic        big;
    logic [6:0]  rem;
    logic [23:0] f7;
    logic        neg;
    logic [2:0]  status;
    logic [4:0]  mask;     // sat, alt, spd, lon, lat
    logic        south;
    logic        west;
  } evt_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    return r;
  endfunction

endpackage

>>> rtl/nrg_fifo.sv
// Small register queue that decouples the character front end from the arithmetic back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
module nrg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end
endmodule

>>> rtl/nrg_front.sv
// Character front end: framing, checksum, field tracking and number accumulation.
// Depends on nrg_pkg; emits one event per relevant field end and per newline.
`timescale 1ns / 1ps
module nrg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic [7:0]    c_i,
  output logic          push_o,
  output nrg_pkg::evt_t evt_o
);
  import nrg_pkg::*;

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_BODY  = 3'd1;
  localparam logic [2:0] PH_HI    = 3'd2;
  localparam logic [2:0] PH_LO    = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [2:0] PH_BAD   = 3'd5;

  localparam logic [1:0] K_UNKNOWN = 2'd0;
  localparam logic [1:0] K_RMC     = 2'd1;
  localparam logic [1:0] K_GGA     = 2'd2;

  typedef struct packed {
    logic active, lat, ns, lon, ew, spd, alt, sat, south, west;
  } flags_t;

  logic [7:0]  xor_q, xor_d, cc_q, cc_d, chk_q, chk_d, first_q, first_d;
  logic [4:0]  fn_q, fn_d;
  logic [2:0]  phase_q, phase_d, alen_q, alen_d, nfrac_q, nfrac_d;
  logic [1:0]  kind_q, kind_d;
  logic        cut_q, cut_d, has_q, has_d, dot_q, dot_d, neg_q, neg_d, stop_q, stop_d;
  logic        big_q, big_d;
  flags_t      fl_q, fl_d;
  logic [39:0] addr_q, addr_d;
  logic [29:0] int_q, int_d;
  logic [7:0]  deg_q, deg_d;
  logic [3:0]  r1_q, r1_d, r0_q, r0_d;
  logic [23:0] f7_q, f7_d;

  logic        fin, do_char, bad;
  logic [4:0]  hx;
  logic [3:0]  dig;
  logic [33:0] int_n;
  logic [10:0] deg_n;
  op_e         fop;

  assign hx  = hex_val(c_i);
  assign dig = 4'(c_i - "0");

  always_comb begin
    xor_d = xor_q; cc_d = cc_q; chk_d = chk_q; first_d = first_q; fn_d = fn_q;
    phase_d = phase_q; alen_d = alen_q; nfrac_d = nfrac_q; kind_d = kind_q;
    cut_d = cut_q; has_d = has_q; dot_d = dot_q; neg_d = neg_q; stop_d = stop_q;
    big_d = big_q; fl_d = fl_q; addr_d = addr_q; int_d = int_q; deg_d = deg_q;
    r1_d = r1_q; r0_d = r0_q; f7_d = f7_q;
    fin = 1'b0; do_char = 1'b0; push_o = 1'b0; evt_o = '0; fop = OP_NONE;
    bad = (cc_q > 8'(MAX_LEN - 1)) || (phase_q != PH_DONE) || (xor_q != chk_q);
    int_n = {int_q, 3'b000} + {3'b000, int_q, 1'b0} + 34'(dig);
    deg_n = {deg_q, 3'b000} + {2'b00, deg_q, 1'b0} + 11'(r1_q);

    if (acc_i) begin
      if (c_i == CH_LF) begin
        push_o    = 1'b1;
        evt_o.op  = OP_EOL;
        evt_o.south = fl_q.south;
        evt_o.west  = fl_q.west;
        if (bad) evt_o.status = ST_BAD;
        else if (kind_q == K_RMC && !fl_q.active) evt_o.status = ST_VOID;
        else if (kind_q == K_RMC || kind_q == K_GGA) begin
          evt_o.status = (kind_q == K_RMC) ? ST_RMC_OK : ST_GGA_OK;
          evt_o.mask = {fl_q.sat, fl_q.alt, fl_q.spd, fl_q.lon && fl_q.ew, fl_q.lat && fl_q.ns};
        end else evt_o.status = ST_OTHER;
        xor_d = '0; cc_d = '0; chk_d = '0; fn_d = '0; phase_d = PH_START; kind_d = K_UNKNOWN;
        cut_d = 1'b0; fl_d = '0; addr_d = '0; alen_d = '0;
        has_d = 1'b0; first_d = '0; dot_d = 1'b0; neg_d = 1'b0; stop_d = 1'b0;
        int_d = '0; deg_d = '0; big_d = 1'b0; r1_d = '0; r0_d = '0; f7_d = '0; nfrac_d = '0;
      end else if (c_i != CH_NUL) begin
        if (cc_q != 8'hFF) cc_d = cc_q + 1'b1;
        if (!cut_q) begin
          if (c_i == CH_CR) cut_d = 1'b1;
          else begin
            unique case (phase_q)
              PH_START: phase_d = (c_i == CH_DOLLAR) ? PH_BODY : PH_BAD;
              PH_BODY: begin
                if (c_i == CH_STAR) begin
                  fin = 1'b1;
                  phase_d = PH_HI;
                end else begin
                  xor_d = xor_q ^ c_i;
                  if (c_i == CH_COMMA) fin = 1'b1;
                  else begin
                    if (fn_q == '0 && alen_q < 3'd6) begin
                      addr_d = {addr_q[31:0], c_i};
                      alen_d = alen_q + 1'b1;
                    end
                    do_char = 1'b1;
                  end
                end
              end
              PH_HI: begin
                if (!hx[4]) phase_d = PH_BAD;
                else begin
                  chk_d = {hx[3:0], 4'h0};
                  phase_d = PH_LO;
                end
              end
              PH_LO: begin
                if (!hx[4]) phase_d = PH_BAD;
                else begin
                  chk_d = chk_q | {4'h0, hx[3:0]};
                  phase_d = PH_DONE;
                end
              end
              default: ;
            endcase
          end
        end
      end
    end

    // Number accumulation for one field character.
    if (do_char) begin
      if (!has_q) first_d = c_i;
      has_d = 1'b1;
      if (!stop_q) begin
        if (c_i >= "0" && c_i <= "9") begin
          if (!dot_q) begin
            int_d = (int_n > 34'(INT_CAP)) ? INT_CAP : int_n[29:0];
            if (!big_q) begin
              if (deg_n > 11'd180) big_d = 1'b1;
              else deg_d = deg_n[7:0];
            end
            r1_d = r0_q;
            r0_d = dig;
          end else if (nfrac_q < 3'(FRAC_DIGITS)) begin
            f7_d = f7_q + 24'(dig * FRAC_W[nfrac_q]);
            nfrac_d = nfrac_q + 1'b1;
          end
        end else if (c_i == CH_DOT && !dot_q) dot_d = 1'b1;
        else if ((c_i == CH_MINUS || c_i == CH_PLUS) && !has_q) neg_d = (c_i == CH_MINUS);
        else stop_d = 1'b1;
      end
    end

    // Field end: classify the address or note which value this field carries.
    if (fin) begin
      if (fn_q == '0) begin
        kind_d = K_UNKNOWN;
        if (alen_q == 3'd5) begin
          if (addr_q == ADDR_GPRMC || addr_q == ADDR_GNRMC) kind_d = K_RMC;
          else if (addr_q == ADDR_GPGGA || addr_q == ADDR_GNGGA) kind_d = K_GGA;
        end
      end else if (has_q && kind_q == K_RMC) begin
        case (fn_q)
          5'd2: if (first_q == CH_A) fl_d.active = 1'b1;
          5'd3: begin fop = OP_LAT; fl_d.lat = 1'b1; end
          5'd4: begin fl_d.ns = 1'b1; if (first_q == CH_S) fl_d.south = 1'b1; end
          5'd5: begin fop = OP_LON; fl_d.lon = 1'b1; end
          5'd6: begin fl_d.ew = 1'b1; if (first_q == CH_W) fl_d.west = 1'b1; end
          5'd7: begin fop = OP_SPD; fl_d.spd = 1'b1; end
          default: ;
        endcase
      end else if (has_q && kind_q == K_GGA) begin
        case (fn_q)
          5'd2: begin fop = OP_LAT; fl_d.lat = 1'b1; end
          5'd3: begin fl_d.ns = 1'b1; if (first_q == CH_S) fl_d.south = 1'b1; end
          5'd4: begin fop = OP_LON; fl_d.lon = 1'b1; end
          5'd5: begin fl_d.ew = 1'b1; if (first_q == CH_W) fl_d.west = 1'b1; end
          5'd7: begin fop = OP_SAT; fl_d.sat = 1'b1; end
          5'd9: begin fop = OP_ALT; fl_d.alt = 1'b1; end
          default: ;
        endcase
      end
      if (fop != OP_NONE) begin
        push_o        = 1'b1;
        evt_o.op      = fop;
        evt_o.int_val = int_q;
        evt_o.deg     = deg_q;
        evt_o.big     = big_q;
        evt_o.rem     = 7'({r1_q, 3'b000} + {1'b0, r1_q, 1'b0} + {3'b000, r0_q});
        evt_o.f7      = f7_q;
        evt_o.neg     = neg_q;
      end
      has_d = 1'b0; first_d = '0; dot_d = 1'b0; neg_d = 1'b0; stop_d = 1'b0;
      int_d = '0; deg_d = '0; big_d = 1'b0; r1_d = '0; r0_d = '0; f7_d = '0; nfrac_d = '0;
      if (fn_q != 5'd31) fn_d = fn_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q <= '0; cc_q <= '0; chk_q <= '0; first_q <= '0; fn_q <= '0;
      phase_q <= PH_START; alen_q <= '0; nfrac_q <= '0; kind_q <= K_UNKNOWN;
      cut_q <= 1'b0; has_q <= 1'b0; dot_q <= 1'b0; neg_q <= 1'b0; stop_q <= 1'b0;
      big_q <= 1'b0; fl_q <= '0; addr_q <= '0; int_q <= '0; deg_q <= '0;
      r1_q <= '0; r0_q <= '0; f7_q <= '0;
    end else begin
      xor_q <= xor_d; cc_q <= cc_d; chk_q <= chk_d; first_q <= first_d; fn_q <= fn_d;
      phase_q <= phase_d; alen_q <= alen_d; nfrac_q <= nfrac_d; kind_q <= kind_d;
      cut_q <= cut_d; has_q <= has_d; dot_q <= dot_d; neg_q <= neg_d; stop_q <= stop_d;
      big_q <= big_d; fl_q <= fl_d; addr_q <= addr_d; int_q <= int_d; deg_q <= deg_d;
      r1_q <= r1_d; r0_q <= r0_d; f7_q <= f7_d;
    end
  end
endmodule

>>> rtl/nrg_back.sv
// Arithmetic back end: fixed-point conversion pipeline, pending values and the committed fix.
// Depends on nrg_pkg; consumes events from the queue and drives the result register.
`timescale 1ns / 1ps
module nrg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ev_valid_i,
  input  nrg_pkg::evt_t       ev_i,
  output logic                ev_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          status_o,
  output logic signed [30:0]  lat_o,
  output logic signed [31:0]  lon_o,
  output logic [20:0]         spd_o,
  output logic signed [24:0]  alt_o,
  output logic [6:0]          sat_o
);
  import nrg_pkg::*;

  typedef struct packed {
    op_e         op;
    logic [27:0] mul_a;
    logic [16:0] int_part;
    logic [30:0] deg7;
    logic        big;
    logic        neg;
    logic [6:0]  sat;
    logic [2:0]  status;
    logic [4:0]  mask;
    logic        south;
    logic        west;
  } s1_t;

  typedef struct packed {
    op_e         op;
    logic [59:0] prod;
    logic [27:0] base;
    logic [30:0] deg7;
    logic        big;
    logic        neg;
    logic [6:0]  sat;
    logic [2:0]  status;
    logic [4:0]  mask;
    logic        south;
    logic        west;
  } s2_t;

  logic        en, v1_q, v2_q, vout_q;
  s1_t         s1_q, s1_d;
  s2_t         s2_q, s2_d;
  logic [29:0] m2;
  logic [34:0] y;
  logic [31:0] mul_b, mag, lim;
  logic [27:0] qv;
  logic [21:0] spd_v;
  logic [24:0] alt_m;
  logic [30:0] plat_q;
  logic [30:0] plon_q;
  logic [20:0] pspd_q;
  logic [24:0] palt_q;
  logic [6:0]  psat_q;
  logic [2:0]  st_q;
  logic signed [30:0] lat_q;
  logic signed [31:0] lon_q;
  logic [20:0] spd_q;
  logic signed [24:0] alt_q;
  logic [6:0]  sat_q;

  assign en       = !vout_q || !out_stall_i;
  assign ev_pop_o = en && ev_valid_i;

  // Stage 1: constant scaling and operand selection.
  always_comb begin
    m2 = 30'(ev_i.rem) * 30'd10000000 + 30'(ev_i.f7);
    y  = 35'(ev_i.f7) * 35'd1852;
    s1_d        = '0;
    s1_d.op     = ev_i.op;
    s1_d.deg7   = 31'(ev_i.deg) * 31'd10000000;
    s1_d.big    = ev_i.big;
    s1_d.neg    = ev_i.neg;
    s1_d.sat    = ev_i.neg ? 7'd0 : ((ev_i.int_val > 30'd99) ? 7'd99 : ev_i.int_val[6:0]);
    s1_d.status = ev_i.status;
    s1_d.mask   = ev_i.mask;
    s1_d.south  = ev_i.south;
    s1_d.west   = ev_i.west;
    case (ev_i.op)
      OP_LAT, OP_LON: s1_d.mul_a = m2[29:2];
      OP_SPD: begin
        s1_d.mul_a = y[34:7];
        s1_d.int_part = (ev_i.int_val > 30'd1081) ? 17'd1081 : ev_i.int_val[16:0];
      end
      OP_ALT: begin
        s1_d.mul_a = 28'(ev_i.f7);
        s1_d.int_part = (ev_i.int_val > 30'd100000) ? 17'd100000 : ev_i.int_val[16:0];
      end
      default: ;
    endcase
  end

  // Stage 2: reciprocal multiply and integer-part scaling.
  always_comb begin
    case (s1_q.op)
      OP_SPD:  mul_b = M78125;
      OP_ALT:  mul_b = M1E5;
      default: mul_b = M15;
    endcase
    s2_d        = '0;
    s2_d.op     = s1_q.op;
    s2_d.prod   = 60'(s1_q.mul_a) * 60'(mul_b);
    s2_d.base   = 28'(s1_q.int_part) * ((s1_q.op == OP_SPD) ? 28'd1852 : 28'd100);
    s2_d.deg7   = s1_q.deg7;
    s2_d.big    = s1_q.big;
    s2_d.neg    = s1_q.neg;
    s2_d.sat    = s1_q.sat;
    s2_d.status = s1_q.status;
    s2_d.mask   = s1_q.mask;
    s2_d.south  = s1_q.south;
    s2_d.west   = s1_q.west;
  end

  // Stage 3: shift, add and saturate.
  always_comb begin
    case (s2_q.op)
      OP_SPD:  qv = 28'(s2_q.prod >> 44);
      OP_ALT:  qv = 28'(s2_q.prod >> 41);
      default: qv = 28'(s2_q.prod >> 35);
    endcase
    lim   = (s2_q.op == OP_LAT) ? LAT_LIMIT : LON_LIMIT;
    mag   = 32'(s2_q.deg7) + 32'(qv);
    if (s2_q.big || mag > lim) mag = lim;
    spd_v = 22'(s2_q.base) + 22'(qv);
    if (s2_q.neg) spd_v = '0;
    else if (spd_v > SPD_LIMIT) spd_v = SPD_LIMIT;
    alt_m = 25'(s2_q.base) + 25'(qv);
    if (s2_q.neg) alt_m = (alt_m > ALT_NEG_LIMIT) ? -ALT_NEG_LIMIT : -alt_m;
    else if (alt_m > ALT_LIMIT) alt_m = ALT_LIMIT;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      if (v2_q) begin
        case (s2_q.op)
          OP_LAT: plat_q <= mag[30:0];
          OP_LON: plon_q <= mag[30:0];
          OP_SPD: pspd_q <= spd_v[20:0];
          OP_ALT: palt_q <= alt_m;
          OP_SAT: psat_q <= s2_q.sat;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; vout_q <= 1'b0; st_q <= '0;
      lat_q <= '0; lon_q <= '0; spd_q <= '0; alt_q <= '0; sat_q <= '0;
    end else if (en) begin
      v1_q   <= ev_valid_i;
      v2_q   <= v1_q;
      vout_q <= v2_q && (s2_q.op == OP_EOL);
      if (v2_q && s2_q.op == OP_EOL) begin
        st_q <= s2_q.status;
        if (s2_q.mask[0]) lat_q <= s2_q.south ? -$signed(plat_q) : $signed(plat_q);
        if (s2_q.mask[1]) lon_q <= s2_q.west ? -$signed({1'b0, plon_q})
                                             : $signed({1'b0, plon_q});
        if (s2_q.mask[2]) spd_q <= pspd_q;
        if (s2_q.mask[3]) alt_q <= $signed(palt_q);
        if (s2_q.mask[4]) sat_q <= psat_q;
      end
    end
  end

  assign out_valid_o = vout_q;
  assign status_o    = st_q;
  assign lat_o       = lat_q;
  assign lon_o       = lon_q;
  assign spd_o       = spd_q;
  assign alt_o       = alt_q;
  assign sat_o       = sat_q;
endmodule

>>> rtl/nmea_rmc_gga_parser_unit.sv
// NMEA RMC/GGA parser top level. One received byte is taken per clock cycle while the queue has room.
// With an empty queue and no held result, a newline's event enters the queue at the accepting
// edge, then passes through the two conversion stage registers and into the result register.
// Throughput is set by the front end, which handles one character per cycle while the queue has room.
// Reset (asynchronous, active low) clears the line state, the queue and the committed fix.
`timescale 1ns / 1ps
module nmea_rmc_gga_parser_unit #(
  parameter int QUEUE_DEPTH = nrg_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         line_status_o,
  output logic signed [30:0] latitude_e7_o,
  output logic signed [31:0] longitude_e7_o,
  output logic [20:0]        speed_mph_kmh_o,
  output logic signed [24:0] altitude_cm_o,
  output logic [6:0]         satellite_count_o
);
  import nrg_pkg::*;

  logic accept, push, pop, empty, full;
  evt_t evt_in, evt_out;

  // The front end takes a byte whenever the queue has room. Each request either updates the
  // line state only, or also posts one event: a value field to convert, or an end of line.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  nrg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (accept),
    .c_i    (rx_byte_i),
    .push_o (push),
    .evt_o  (evt_in)
  );

  // The queue lets the front end keep taking bytes while the result register is held.
  nrg_fifo #(
    .WIDTH ($bits(evt_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (evt_in),
    .pop_i   (pop),
    .data_o  (evt_out),
    .empty_o (empty),
    .full_o  (full)
  );

  // The back end converts field values to fixed point, keeps them pending for the line and
  // commits them into the fix when the end-of-line event says the line checked out.
  nrg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ev_valid_i  (!empty),
    .ev_i        (evt_out),
    .ev_pop_o    (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (line_status_o),
    .lat_o       (latitude_e7_o),
    .lon_o       (longitude_e7_o),
    .spd_o       (speed_mph_kmh_o),
    .alt_o       (altitude_cm_o),
    .sat_o       (satellite_count_o)
  );
endmodule

>>> tb/testbench.sv
// Self-checking testbench for the NMEA RMC/GGA parser: directed sentences, then random traffic.
// Depends on rtl/nrg_pkg.sv and rtl/nmea_rmc_gga_parser_unit.sv; reads no files.
`timescale 1ns / 1ps
module testbench;
  import nrg_pkg::*;

  // Parser line phases and sentence kinds, kept locally for the prediction.
  typedef enum logic [2:0] {
    PH_START, PH_BODY, PH_HI, PH_LO, PH_DONE, PH_BAD
  } line_phase_e;
  typedef enum logic [1:0] {KIND_OTHER, KIND_RMC, KIND_GGA} kind_e;

  // One result of a newline: the status and the committed fix.
  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [20:0] spd;
    logic [24:0] alt;
    logic [6:0]  sats;
  } fix_report_t;

  // One character queued for the sender, with an optional hand-typed status
  // that the newline ending the line must report (-1 means none).
  typedef struct {
    logic [7:0] ch;
    int         typed;
  } tx_char_t;

  // Directed rows: raw line text, typed status or -1, and whether NUL bytes
  // are slipped in after every comma.
  typedef struct {
    string text;
    int    typed;
    bit    with_nul;
  } row_t;

  localparam int NO_TYPED = -1;
  localparam longint unsigned E7 = 64'd10000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i = 8'd0;
  int                 in_typed = NO_TYPED;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         line_status_o;
  logic signed [30:0] latitude_e7_o;
  logic signed [31:0] longitude_e7_o;
  logic [20:0]        speed_mph_kmh_o;
  logic signed [24:0] altitude_cm_o;
  logic [6:0]         satellite_count_o;

  nmea_rmc_gga_parser_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .line_status_o     (line_status_o),
    .latitude_e7_o     (latitude_e7_o),
    .longitude_e7_o    (longitude_e7_o),
    .speed_mph_kmh_o   (speed_mph_kmh_o),
    .altitude_cm_o     (altitude_cm_o),
    .satellite_count_o (satellite_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Global run state.
  bit          rst_done = 1'b0;
  bit          hold_req = 1'b0;     // receiver long hold-off request
  bit          tx_idle_on = 1'b1;   // sender draws gaps when set
  bit          rx_idle_on = 1'b1;   // receiver draws stalls when set
  int          error_count = 0;
  int          pushed_count = 0;
  int          accepted_count = 0;
  int          checked_count = 0;
  int          line_count = 0;
  tx_char_t    tx_q[$];
  fix_report_t fix_reports_q[$];

  // ---------------------------------------------------------------------------
  // Parser state mirrored for prediction.
  // ---------------------------------------------------------------------------
  logic [7:0]      p_xor, p_count, p_rx_sum;
  logic [4:0]      p_field;
  line_phase_e     p_phase;
  kind_e           p_kind;
  bit              p_cut;
  longint unsigned p_pend[5];
  logic [31:0]     p_fix[5];
  bit f_lat, f_ns, f_lon, f_ew, f_spd, f_alt, f_sat, f_south, f_west, f_active;
  longint unsigned p_addr;
  int              p_addr_len;
  longint unsigned n_int, n_frac;
  int              n_nfrac, n_len;
  logic [7:0]      n_first;
  bit              n_dot, n_neg, n_stop;

  function automatic longint unsigned ten_pow(int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  task automatic number_clear();
    n_int = 0; n_frac = 0; n_nfrac = 0; n_len = 0; n_first = 8'd0;
    n_dot = 0; n_neg = 0; n_stop = 0;
  endtask

  task automatic line_reset();
    p_xor = 0; p_count = 0; p_field = 0; p_phase = PH_START; p_kind = KIND_OTHER;
    p_rx_sum = 0; p_cut = 0; p_addr = 0; p_addr_len = 0;
    {f_lat, f_ns, f_lon, f_ew, f_spd, f_alt, f_sat, f_south, f_west, f_active} = '0;
    for (int i = 0; i < 5; i++) p_pend[i] = 0;
    number_clear();
  endtask

  // Accumulate one character into the current numeric field.
  task automatic number_take(logic [7:0] c);
    if (n_len == 0) n_first = c;
    if (n_len < 255) n_len++;
    if (!n_stop) begin
      if (c >= "0" && c <= "9") begin
        if (!n_dot) begin
          n_int = n_int * 10 + (c - "0");
          if (n_int > INT_CAP) n_int = INT_CAP;
        end else if (n_nfrac < FRAC_DIGITS) begin
          n_frac = n_frac * 10 + (c - "0");
          n_nfrac++;
        end
      end else if (c == CH_DOT && !n_dot) begin
        n_dot = 1;
      end else if ((c == CH_MINUS || c == CH_PLUS) && n_len == 1) begin
        n_neg = (c == CH_MINUS);
      end else begin
        n_stop = 1;
      end
    end
  endtask

  function automatic longint unsigned frac_units();
    return n_frac * ten_pow(FRAC_DIGITS - n_nfrac);
  endfunction

  // ddmm.mmm converted to 1e-7 degrees, saturated at the limit.
  function automatic longint unsigned coord_units(longint unsigned limit);
    longint unsigned s, deg, mins, mag;
    s = ten_pow(FRAC_DIGITS);
    deg = n_int / 100;
    if (deg > 180) return limit;
    mins = (n_int % 100) * s + frac_units();
    mag = deg * E7 + (mins * E7) / (60 * s);
    return (mag > limit) ? limit : mag;
  endfunction

  task automatic field_close();
    longint unsigned s, v;
    bit has;
    s = ten_pow(FRAC_DIGITS);
    has = (n_len != 0);
    if (p_field == 0) begin
      p_kind = KIND_OTHER;
      if (p_addr_len == 5) begin
        if (p_addr[39:0] == ADDR_GPRMC || p_addr[39:0] == ADDR_GNRMC) p_kind = KIND_RMC;
        else if (p_addr[39:0] == ADDR_GPGGA || p_addr[39:0] == ADDR_GNGGA) p_kind = KIND_GGA;
      end
    end else if (has && p_kind == KIND_RMC) begin
      case (p_field)
        2: if (n_first == CH_A) f_active = 1;
        3: begin p_pend[0] = coord_units(LAT_LIMIT); f_lat = 1; end
        4: begin f_ns = 1; if (n_first == CH_S) f_south = 1; end
        5: begin p_pend[1] = coord_units(LON_LIMIT); f_lon = 1; end
        6: begin f_ew = 1; if (n_first == CH_W) f_west = 1; end
        7: begin
          v = n_neg ? 0 : n_int * 1852 + (frac_units() * 1852) / s;
          p_pend[2] = (v > SPD_LIMIT) ? SPD_LIMIT : v;
          f_spd = 1;
        end
        default: ;
      endcase
    end else if (has && p_kind == KIND_GGA) begin
      case (p_field)
        2: begin p_pend[0] = coord_units(LAT_LIMIT); f_lat = 1; end
        3: begin f_ns = 1; if (n_first == CH_S) f_south = 1; end
        4: begin p_pend[1] = coord_units(LON_LIMIT); f_lon = 1; end
        5: begin f_ew = 1; if (n_first == CH_W) f_west = 1; end
        7: begin
          p_pend[4] = n_neg ? 0 : ((n_int > 99) ? 99 : n_int);
          f_sat = 1;
        end
        9: begin
          v = n_int * 100 + (frac_units() * 100) / s;
          if (n_neg) begin
            if (v > ALT_NEG_LIMIT) v = ALT_NEG_LIMIT;
            p_pend[3] = {32'd0, 32'd0 - v[31:0]};
          end else begin
            p_pend[3] = (v > ALT_LIMIT) ? ALT_LIMIT : v;
          end
          f_alt = 1;
        end
        default: ;
      endcase
    end
    number_clear();
    if (p_field < 31) p_field++;
  endtask

  task automatic fix_commit();
    if (f_lat && f_ns) p_fix[0] = f_south ? 32'd0 - p_pend[0][31:0] : p_pend[0][31:0];
    if (f_lon && f_ew) p_fix[1] = f_west ? 32'd0 - p_pend[1][31:0] : p_pend[1][31:0];
    if (f_spd) p_fix[2] = p_pend[2][31:0];
    if (f_alt) p_fix[3] = p_pend[3][31:0];
    if (f_sat) p_fix[4] = p_pend[4][31:0];
  endtask

  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  // Advance the mirrored parser by one accepted character; a newline queues
  // the fix report it must produce.
  task automatic parse_rx_char(logic [7:0] c, int typed);
    fix_report_t r;
    logic [2:0] st;
    int h;
    if (c == CH_LF) begin
      if (p_count > MAX_LEN - 1 || p_phase != PH_DONE || p_xor != p_rx_sum) begin
        st = ST_BAD;
      end else if (p_kind == KIND_RMC) begin
        if (!f_active) st = ST_VOID;
        else begin fix_commit(); st = ST_RMC_OK; end
      end else if (p_kind == KIND_GGA) begin
        fix_commit();
        st = ST_GGA_OK;
      end else begin
        st = ST_OTHER;
      end
      r.status = (typed >= 0) ? 3'(typed) : st;
      r.lat = p_fix[0][30:0];
      r.lon = p_fix[1];
      r.spd = p_fix[2][20:0];
      r.alt = p_fix[3][24:0];
      r.sats = p_fix[4][6:0];
      fix_reports_q.push_back(r);
      line_reset();
    end else if (c != CH_NUL) begin
      if (p_count < 255) p_count++;
      if (!p_cut) begin
        if (c == CH_CR) begin
          p_cut = 1;
        end else begin
          case (p_phase)
            PH_START: p_phase = (c == CH_DOLLAR) ? PH_BODY : PH_BAD;
            PH_BODY: begin
              if (c == CH_STAR) begin
                field_close();
                p_phase = PH_HI;
              end else begin
                p_xor ^= c;
                if (c == CH_COMMA) begin
                  field_close();
                end else begin
                  if (p_field == 0 && p_addr_len < 6) begin
                    p_addr = (p_addr << 8) | c;
                    p_addr_len++;
                  end
                  number_take(c);
                end
              end
            end
            PH_HI: begin
              h = nibble_of(c);
              if (h < 0) p_phase = PH_BAD;
              else begin p_rx_sum = 8'(h << 4); p_phase = PH_LO; end
            end
            PH_LO: begin
              h = nibble_of(c);
              if (h < 0) p_phase = PH_BAD;
              else begin p_rx_sum = p_rx_sum | 8'(h); p_phase = PH_DONE; end
            end
            default: ;
          endcase
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Requests are taken and results are compared at the same rising edge on
  // which the handshake completes; the sampled values are the pre-edge ones.
  always @(posedge clk_i) begin
    fix_report_t want;
    if (in_valid_i && !in_stall_o) begin
      parse_rx_char(rx_byte_i, in_typed);
      accepted_count++;
    end
    if (out_valid_o && !out_stall_i) begin
      if (fix_reports_q.size() == 0) begin
        flag_mismatch("unexpected result, status", line_status_o, -1);
      end else begin
        want = fix_reports_q.pop_front();
        if (line_status_o !== want.status) flag_mismatch("line_status", line_status_o, want.status);
        if (latitude_e7_o !== want.lat)
          flag_mismatch("latitude_e7", latitude_e7_o, $signed(want.lat));
        if (longitude_e7_o !== want.lon)
          flag_mismatch("longitude_e7", longitude_e7_o, $signed(want.lon));
        if (speed_mph_kmh_o !== want.spd) flag_mismatch("speed", speed_mph_kmh_o, want.spd);
        if (altitude_cm_o !== want.alt)
          flag_mismatch("altitude_cm", altitude_cm_o, $signed(want.alt));
        if (satellite_count_o !== want.sats)
          flag_mismatch("satellite_count", satellite_count_o, want.sats);
      end
      checked_count++;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one request per queued character, with random gaps between them when enabled.
  // ---------------------------------------------------------------------------
  initial begin
    tx_char_t item;
    int gap;
    wait (rst_done);
    forever begin
      while (tx_q.size() == 0) @(posedge clk_i);
      item = tx_q.pop_front();
      in_valid_i <= 1'b1;
      rx_byte_i <= item.ch;
      in_typed <= item.typed;
      do @(posedge clk_i); while (in_stall_o);
      gap = tx_idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0 || tx_q.size() == 0) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  end

  // Receiver: random stalls per result, and one long hold-off on request so
  // that the parser's event queue fills and it stalls its input.
  initial begin
    int n;
    wait (rst_done);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end else begin
        n = rx_idle_on ? $urandom_range(0, 12) : 0;
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------------
  task automatic push_text(string s, int typed, bit with_nul);
    tx_char_t t;
    for (int i = 0; i < s.len(); i++) begin
      t.ch = s[i];
      t.typed = typed;
      tx_q.push_back(t);
      pushed_count++;
      if (with_nul && s[i] == CH_COMMA) begin
        t.ch = CH_NUL;
        tx_q.push_back(t);
        pushed_count++;
      end
    end
  endtask

  function automatic logic [7:0] xor_of(string body);
    logic [7:0] x;
    x = 8'd0;
    for (int i = 0; i < body.len(); i++) x ^= body[i];
    return x;
  endfunction

  // Wrap a body into a full sentence; a nonzero flip corrupts the checksum.
  function automatic string sentence(string body, logic [7:0] flip, bit lower);
    logic [7:0] cs;
    cs = xor_of(body) ^ flip;
    return {"$", body, "*", lower ? $sformatf("%02x", cs) : $sformatf("%02X", cs), "\r\n"};
  endfunction

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  // A random number field, including empty, signed, oversized and broken forms.
  function automatic string rand_number(int max_int);
    string s;
    case ($urandom_range(0, 11))
      0: return "";
      1: return {digits(14), ".", digits(3)};
      2: s = "-";
      3: s = "+";
      4: return {$sformatf("%0d", $urandom_range(0, max_int)), "x", digits(2)};
      default: s = "";
    endcase
    s = {s, $sformatf("%0d", $urandom_range(0, max_int))};
    if ($urandom_range(0, 3) != 0) s = {s, ".", digits($urandom_range(0, 8))};
    return s;
  endfunction

  function automatic string rand_coord(int max_deg);
    if ($urandom_range(0, 9) == 0) return "";
    if ($urandom_range(0, 9) == 0) return rand_number(99999);
    return {$sformatf("%0d%02d", $urandom_range(0, max_deg), $urandom_range(0, 59)),
            ".", digits($urandom_range(0, 8))};
  endfunction

  function automatic string pick(string a, string b, string c);
    case ($urandom_range(0, 5))
      0: return c;
      1, 2: return b;
      default: return a;
    endcase
  endfunction

  // One random line of traffic: mostly well-formed RMC and GGA sentences with
  // random content, the rest other sentences, broken frames and raw noise.
  task automatic push_random_line();
    string body, talker, s, pad;
    logic [7:0] flip;
    tx_char_t t;
    int kind;
    kind = $urandom_range(0, 15);
    talker = $urandom_range(0, 1) ? "GP" : "GN";
    if (kind >= 14) begin
      repeat ($urandom_range(1, 24)) begin
        t.ch = 8'($urandom_range(0, 255));
        t.typed = NO_TYPED;
        tx_q.push_back(t);
        pushed_count++;
      end
      return;
    end
    if (kind < 6) begin
      body = {talker, "RMC,", digits(6), ",", pick("A", "V", ""), ",",
              rand_coord(95), ",", pick("N", "S", ""), ",", rand_coord(185), ",",
              pick("E", "W", ""), ",", rand_number(1200), ",", rand_number(359), ",",
              digits(6), ",,"};
    end else if (kind < 12) begin
      body = {talker, "GGA,", digits(6), ",", rand_coord(95), ",", pick("N", "S", ""), ",",
              rand_coord(185), ",", pick("E", "W", ""), ",", $sformatf("%0d", kind % 3), ",",
              rand_number(140), ",", rand_number(9), ",", rand_number(120000), ",M,,M,,"};
    end else begin
      body = {pick(talker, "GPGSV", "GPRM"), ",", rand_number(99), ",", rand_number(9)};
    end
    if ($urandom_range(0, 19) == 0) begin
      pad = "";
      repeat (14) pad = {pad, ",", digits(8)};
      body = {body, pad};
    end
    flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
    s = sentence(body, flip, $urandom_range(0, 3) == 0);
    case ($urandom_range(0, 9))
      0: s = s.substr(1, s.len() - 1);                       // missing start mark
      1: s = {s.substr(0, s.len() - 3), "\n"};               // no carriage return
      2: s = {s.substr(0, s.len() - 3), "xy\r,junk\n"};      // trailing garbage
      default: ;
    endcase
    push_text(s, NO_TYPED, $urandom_range(0, 15) == 0);
  endtask

  // Stop offering requests until all queued characters are taken and every
  // expected result has come back.
  task automatic drain_all();
    wait (accepted_count == pushed_count);
    wait (fix_reports_q.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    row_t rows[$];
    string long_body;
    line_reset();
    for (int i = 0; i < 5; i++) p_fix[i] = 32'd0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    rst_done = 1;

    long_body = "GPRMC,1,A";
    repeat (12) long_body = {long_body, ",0123456789"};

    // Directed sentences. Rows with a typed status are the obvious ones: an empty
    // line, two good fixes, corrupted frames, a void fix and an unrelated sentence.
    rows.push_back('{"\n", ST_BAD, 0});
    rows.push_back('{sentence("GPRMC,081836,A,3751.65,S,14507.36,E,000.0,360.0,130998,011.3,E",
                              8'd0, 0), ST_RMC_OK, 0});
    rows.push_back('{sentence("GPGGA,1,4807.038,N,01131.000,W,1,08,0.9,545.4,M,46.9,M,,",
                              8'h5A, 0), ST_BAD, 0});
    rows.push_back('{sentence("GNGGA,1,9999.99999,N,18100.0,W,1,150,0.9,-5000.0,M,,M,,",
                              8'd0, 0), ST_GGA_OK, 0});
    rows.push_back('{sentence("GNRMC,1,V,1234.5,N,01234.5,E,5.0,,", 8'd0, 0), ST_VOID, 0});
    rows.push_back('{sentence("GPTXT,01,01,02,ANTSTATUS=OK", 8'd0, 0), ST_OTHER, 0});
    rows.push_back('{"GPRMC,1,A,1,N,1,E,1*00\r\n", ST_BAD, 0});
    rows.push_back('{"$GPRMC,1,A*G1\r\n", ST_BAD, 0});
    rows.push_back('{sentence(long_body, 8'd0, 0), ST_BAD, 0});
    rows.push_back('{sentence("GNRMC,1,A,0000.0,N,00000.0,W,2000.0,,", 8'd0, 1),
                     NO_TYPED, 0});
    rows.push_back('{sentence("GPGGA,1,8959.123456789,S,17959.9,E,1,-3,1,99999999.9,M",
                              8'd0, 0), NO_TYPED, 1});
    rows.push_back('{sentence("GPGGA,1,,N,0,,1,+12,1,-0.5,M", 8'd0, 0), NO_TYPED, 0});
    rows.push_back('{sentence("GPRMC,1,A,4916.45,N,12311.12,W,-2.5,,", 8'd0, 0),
                     NO_TYPED, 0});
    rows.push_back('{{"$GPGGA,1,1,N*", $sformatf("%02X", xor_of("GPGGA,1,1,N")),
                      "99\r\n\r,*junk\n"}, NO_TYPED, 0});
    foreach (rows[i]) push_text(rows[i].text, rows[i].typed, rows[i].with_nul);
    drain_all();

    // Random traffic with long hold-off and a full pause partway through.
    while (pushed_count < 1200) begin
      if (line_count % 3 == 0) begin
        tx_idle_on = $urandom_range(0, 1);
        rx_idle_on = $urandom_range(0, 1);
      end
      if (line_count == 2) begin
        tx_idle_on = 0;
        hold_req = 1;
      end
      if (line_count == 5) drain_all();
      push_random_line();
      line_count++;
      wait (tx_q.size() < 200);
    end
    push_text("\n", NO_TYPED, 0);

    drain_all();
    repeat (30) @(posedge clk_i);
    $display("Run covered %0d characters in %0d random lines plus directed sentences,",
             accepted_count, line_count);
    $display("with %0d line results compared and %0d mismatches.", checked_count, error_count);
    if (error_count == 0 && fix_reports_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("Timeout: the run did not complete.");
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> nmea_rmc_gga_parser_unit.f
rtl/nrg_pkg.sv
rtl/nrg_fifo.sv
rtl/nrg_front.sv
rtl/nrg_back.sv
rtl/nmea_rmc_gga_parser_unit.sv
tb/testbench.sv
